>>> src/lpd_pkg.sv
package lpd_pkg;

  localparam int unsigned LEN_WIDTH_DEF = 20;
  localparam int unsigned CFG_W         = 20;
  localparam int unsigned CFG_IDX_W     = 8;
  localparam int unsigned CFG_DATA_W    = 32;
  localparam int unsigned GARB_W        = 21;

  localparam logic [CFG_W-1:0] MAX_BODY_LEN_RST  = CFG_W'(4096);
  localparam logic [CFG_W-1:0] GARBAGE_LIMIT_RST = CFG_W'(2048);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BODY_LEN  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GARBAGE_LIMIT = CFG_IDX_W'(1);

  // Result kinds
  localparam logic [1:0] KIND_BODY  = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // Error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_EMPTY_LEN = 3'd1;
  localparam logic [2:0] ERR_BAD_CHAR  = 3'd2;
  localparam logic [2:0] ERR_TOO_BIG   = 3'd3;
  localparam logic [2:0] ERR_GARBAGE   = 3'd4;

  // Framing characters
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;

  typedef struct packed {
    logic [CFG_W-1:0] max_body_len;
    logic [CFG_W-1:0] garbage_limit;
  } cfg_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic       last;
    logic [2:0] error_code;
  } res_t;

endpackage

>>> src/lpd_if.sv
interface lpd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink (input valid, input byte_in, output ready);
endinterface

interface lpd_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic       last;
  logic [2:0] error_code;

  modport source (output valid, output kind, output data_byte, output last,
                  output error_code, input ready);
  modport sink (input valid, input kind, input data_byte, input last,
                input error_code, output ready);
endinterface

interface lpd_cfg_if;
  import lpd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> src/lpd_cfg_regs.sv
module lpd_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           wr_valid_i,
  input  logic [lpd_pkg::CFG_IDX_W-1:0]  wr_index_i,
  input  logic [lpd_pkg::CFG_DATA_W-1:0] wr_data_i,
  output logic                           wr_ready_o,
  output lpd_pkg::cfg_t                  cfg_o
);
  import lpd_pkg::*;

  cfg_t cfg_q;

  assign wr_ready_o = 1'b1;
  assign cfg_o      = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_body_len  <= MAX_BODY_LEN_RST;
      cfg_q.garbage_limit <= GARBAGE_LIMIT_RST;
    end else if (wr_valid_i) begin
      unique case (wr_index_i)
        REG_MAX_BODY_LEN:  cfg_q.max_body_len  <= wr_data_i[CFG_W-1:0];
        REG_GARBAGE_LIMIT: cfg_q.garbage_limit <= wr_data_i[CFG_W-1:0];
        default: ;  // drop writes to unmapped indexes
      endcase
    end
  end

endmodule

>>> src/lpd_core.sv
module lpd_core #(
  parameter int unsigned LEN_WIDTH = lpd_pkg::LEN_WIDTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [7:0]    in_byte_i,
  output logic          in_ready_o,
  input  lpd_pkg::cfg_t cfg_i,
  input  logic          res_free_i,
  output logic          res_push_o,
  output lpd_pkg::res_t res_o
);
  import lpd_pkg::*;

  localparam int unsigned CMP_W = (LEN_WIDTH > CFG_W) ? LEN_WIDTH : CFG_W;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEN  = 2'd1,
    PH_CR   = 2'd2,
    PH_BODY = 2'd3
  } phase_e;

  logic                 in_valid_q;
  logic [7:0]           in_byte_q;

  phase_e               phase_q, phase_d;
  logic [LEN_WIDTH-1:0] accum_q, accum_d;
  logic                 digit_seen_q, digit_seen_d;
  logic                 too_big_q, too_big_d;
  logic [LEN_WIDTH-1:0] body_left_q, body_left_d;
  logic [GARB_W-1:0]    garb_q, garb_d;

  logic                 has_res;
  res_t                 res;
  logic                 consume;
  logic [LEN_WIDTH+3:0] accum_x10;
  logic [GARB_W-1:0]    garb_inc;
  logic                 is_digit;

  // accum * 10 + digit, built from two shifts
  assign accum_x10 = {1'b0, accum_q, 3'b000} + {3'b000, accum_q, 1'b0}
                   + {(LEN_WIDTH)'(0), in_byte_q[3:0]};
  assign garb_inc  = (garb_q == {GARB_W{1'b1}}) ? garb_q : garb_q + GARB_W'(1);
  assign is_digit  = (in_byte_q >= CH_ZERO) && (in_byte_q <= CH_NINE);

  always_comb begin
    phase_d      = phase_q;
    accum_d      = accum_q;
    digit_seen_d = digit_seen_q;
    too_big_d    = too_big_q;
    body_left_d  = body_left_q;
    garb_d       = garb_q;
    has_res      = 1'b0;
    res          = '0;

    unique case (phase_q)
      PH_HUNT: begin
        if (in_byte_q == CH_HASH) begin
          phase_d      = PH_LEN;
          accum_d      = '0;
          digit_seen_d = 1'b0;
          too_big_d    = 1'b0;
          garb_d       = '0;
        end else if (garb_inc > {1'b0, cfg_i.garbage_limit}) begin
          garb_d         = '0;
          has_res        = 1'b1;
          res.kind       = KIND_ERROR;
          res.error_code = ERR_GARBAGE;
        end else begin
          garb_d = garb_inc;
        end
      end
      PH_LEN: begin
        if (is_digit) begin
          digit_seen_d = 1'b1;
          if (|accum_x10[LEN_WIDTH+3:LEN_WIDTH]) begin
            accum_d   = '1;  // saturate and flag
            too_big_d = 1'b1;
          end else begin
            accum_d = accum_x10[LEN_WIDTH-1:0];
          end
        end else if (in_byte_q == CH_CR) begin
          phase_d = PH_CR;
        end else begin
          phase_d        = PH_HUNT;
          garb_d         = '0;
          has_res        = 1'b1;
          res.kind       = KIND_ERROR;
          res.error_code = ERR_BAD_CHAR;
        end
      end
      PH_CR: begin
        phase_d = PH_HUNT;
        garb_d  = '0;
        has_res = 1'b1;
        if (in_byte_q != CH_LF) begin
          res.kind       = KIND_ERROR;
          res.error_code = ERR_BAD_CHAR;
        end else if (!digit_seen_q) begin
          res.kind       = KIND_ERROR;
          res.error_code = ERR_EMPTY_LEN;
        end else if (too_big_q ||
                     (CMP_W'(accum_q) > CMP_W'(cfg_i.max_body_len))) begin
          res.kind       = KIND_ERROR;
          res.error_code = ERR_TOO_BIG;
        end else if (accum_q == '0) begin
          res.kind = KIND_EMPTY;
          res.last = 1'b1;
        end else begin
          // header good: start the body, no result yet
          has_res     = 1'b0;
          phase_d     = PH_BODY;
          garb_d      = garb_q;
          body_left_d = accum_q;
        end
      end
      PH_BODY: begin
        has_res       = 1'b1;
        res.kind      = KIND_BODY;
        res.data_byte = in_byte_q;
        if (body_left_q[LEN_WIDTH-1:1] == '0) begin
          body_left_d = '0;
          phase_d     = PH_HUNT;
          garb_d      = '0;
          res.last    = 1'b1;
        end else begin
          body_left_d = body_left_q - LEN_WIDTH'(1);
        end
      end
      default: ;
    endcase
  end

  // Advance the held byte when it makes no result or the result stage has room
  assign consume    = in_valid_q && (!has_res || res_free_i);
  assign in_ready_o = !in_valid_q || consume;
  assign res_push_o = consume && has_res;
  assign res_o      = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      phase_q      <= PH_HUNT;
      accum_q      <= '0;
      digit_seen_q <= 1'b0;
      too_big_q    <= 1'b0;
      body_left_q  <= '0;
      garb_q       <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (consume) begin
        phase_q      <= phase_d;
        accum_q      <= accum_d;
        digit_seen_q <= digit_seen_d;
        too_big_q    <= too_big_d;
        body_left_q  <= body_left_d;
        garb_q       <= garb_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= in_byte_i;
    end
  end

endmodule

>>> src/lpd_out_stage.sv
module lpd_out_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  lpd_pkg::res_t res_i,
  output logic          free_o,
  output logic          valid_o,
  input  logic          ready_i,
  output lpd_pkg::res_t res_o
);
  import lpd_pkg::*;

  logic valid_q;
  res_t res_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (push_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      res_q <= res_i;
    end
  end

endmodule

>>> src/length_prefixed_deframer.sv
// Channel   Role    Payload                                   Transaction when
// in_i      sink    byte_in[7:0]                              valid && ready
// out_o     source  kind[1:0] data_byte[7:0] last error_code  valid && ready
// cfg_i     sink    index[7:0] data[31:0] (low 20 bits kept)  valid && ready
//
// One byte per cycle sustained while out_o is not stalled; the result for a byte
// shows on out_o after the input register, then the result register. cfg_i is always ready.
// Reset clears the framer to hunting for '#' and loads the register defaults.
// A stall on out_o holds the result; the input register keeps taking bytes
// that make no result, and holds the first one that would.
module length_prefixed_deframer #(
  parameter int unsigned LEN_WIDTH = lpd_pkg::LEN_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lpd_byte_if.sink  in_i,
  lpd_res_if.source out_o,
  lpd_cfg_if.sink   cfg_i
);
  import lpd_pkg::*;

  cfg_t cfg;
  res_t core_res;
  res_t out_res;
  logic res_push;
  logic res_free;

  lpd_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_i.valid),
    .wr_index_i (cfg_i.index),
    .wr_data_i  (cfg_i.data),
    .wr_ready_o (cfg_i.ready),
    .cfg_o      (cfg)
  );

  lpd_core #(
    .LEN_WIDTH (LEN_WIDTH)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_byte_i  (in_i.byte_in),
    .in_ready_o (in_i.ready),
    .cfg_i      (cfg),
    .res_free_i (res_free),
    .res_push_o (res_push),
    .res_o      (core_res)
  );

  lpd_out_stage u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .res_i   (core_res),
    .free_o  (res_free),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .res_o   (out_res)
  );

  assign out_o.kind       = out_res.kind;
  assign out_o.data_byte  = out_res.data_byte;
  assign out_o.last       = out_res.last;
  assign out_o.error_code = out_res.error_code;

endmodule

>>> src/lpd_checker.sv
module lpd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] kind_i,
  input logic [7:0] data_byte_i,
  input logic       last_i,
  input logic [2:0] error_code_i
);
  import lpd_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(kind_i) &&
    $stable(data_byte_i) && $stable(last_i) && $stable(error_code_i))
    else $error("result changed while stalled");

  a_error_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i == KIND_ERROR |-> !last_i && data_byte_i == 8'd0 &&
    error_code_i != ERR_NONE && error_code_i <= ERR_GARBAGE)
    else $error("error result carries data, last or a bad code");

  a_empty_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i == KIND_EMPTY |-> last_i && data_byte_i == 8'd0 &&
    error_code_i == ERR_NONE)
    else $error("empty packet result malformed");

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (kind_i == KIND_BODY && error_code_i == ERR_NONE) ||
    kind_i == KIND_EMPTY || kind_i == KIND_ERROR)
    else $error("illegal result kind or body byte with error code");

endmodule

bind length_prefixed_deframer lpd_checker u_lpd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .kind_i       (out_o.kind),
  .data_byte_i  (out_o.data_byte),
  .last_i       (out_o.last),
  .error_code_i (out_o.error_code)
);

>>> bench/length_prefixed_deframer_test.sv
module length_prefixed_deframer_test;
  import lpd_pkg::*;

  localparam logic [CFG_IDX_W-1:0]     REG_NONE      = CFG_IDX_W'(2);
  localparam logic [LEN_WIDTH_DEF-1:0] LEN_SAT       = '1;
  localparam logic [GARB_W-1:0]        GARB_SAT      = '1;
  localparam int                       SETTLE_CYCLES = 8;
  localparam res_t                     NO_RES        = '0;

  typedef enum logic [1:0] {PH_HUNT, PH_LEN, PH_CR, PH_BODY} frame_phase_e;

  typedef struct packed {
    logic [7:0] byte_val;
    logic       typed;
    logic       has_res;
    res_t       res;
  } dir_row_t;

  // Reset, extremes and every error path of the header.
  localparam dir_row_t DIRECTED_ROWS [0:24] = '{
    '{CH_HASH, 1'b0, 1'b0, NO_RES},
    '{CH_ZERO, 1'b0, 1'b0, NO_RES},
    '{CH_CR,   1'b0, 1'b0, NO_RES},
    '{CH_LF,   1'b1, 1'b1, '{KIND_EMPTY, 8'h00, 1'b1, ERR_NONE}},
    '{CH_HASH, 1'b0, 1'b0, NO_RES},
    '{CH_CR,   1'b0, 1'b0, NO_RES},
    '{CH_LF,   1'b1, 1'b1, '{KIND_ERROR, 8'h00, 1'b0, ERR_EMPTY_LEN}},
    '{CH_HASH, 1'b0, 1'b0, NO_RES},
    '{CH_CR,   1'b0, 1'b0, NO_RES},
    '{CH_HASH, 1'b1, 1'b1, '{KIND_ERROR, 8'h00, 1'b0, ERR_BAD_CHAR}},
    '{CH_HASH, 1'b0, 1'b0, NO_RES},
    '{CH_LF,   1'b1, 1'b1, '{KIND_ERROR, 8'h00, 1'b0, ERR_BAD_CHAR}},
    '{CH_HASH, 1'b0, 1'b0, NO_RES},
    '{CH_ZERO + 8'd2, 1'b0, 1'b0, NO_RES},
    '{CH_CR,   1'b0, 1'b0, NO_RES},
    '{CH_LF,   1'b0, 1'b0, NO_RES},
    '{8'hFF,   1'b1, 1'b1, '{KIND_BODY, 8'hFF, 1'b0, ERR_NONE}},
    '{8'h00,   1'b1, 1'b1, '{KIND_BODY, 8'h00, 1'b1, ERR_NONE}},
    '{CH_HASH, 1'b0, 1'b0, NO_RES},
    '{CH_ZERO + 8'd4, 1'b0, 1'b0, NO_RES},
    '{CH_ZERO, 1'b0, 1'b0, NO_RES},
    '{CH_NINE, 1'b0, 1'b0, NO_RES},
    '{CH_ZERO + 8'd7, 1'b0, 1'b0, NO_RES},
    '{CH_CR,   1'b0, 1'b0, NO_RES},
    '{CH_LF,   1'b1, 1'b1, '{KIND_ERROR, 8'h00, 1'b0, ERR_TOO_BIG}}
  };

  logic clk_i;
  logic rst_ni;

  lpd_byte_if in_if ();
  lpd_res_if  out_if ();
  lpd_cfg_if  cfg_if ();

  length_prefixed_deframer DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // Framer state as the block should hold it
  logic [CFG_W-1:0]         body_limit;
  logic [CFG_W-1:0]         garbage_limit;
  frame_phase_e             ph;
  logic [LEN_WIDTH_DEF-1:0] len_acc;
  logic                     seen_digit;
  logic                     len_over;
  logic [LEN_WIDTH_DEF-1:0] body_remaining;
  logic [GARB_W-1:0]        garbage_run;

  res_t       expected_frames[$];
  logic [7:0] stream_q[$];
  int         fail_count;
  int         results_seen;
  int         gap_quiet;
  int         stall_left;
  int         quiet_left;
  int         hold_left;
  int         next_hold;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #12_000_000;
    $display("length_prefixed_deframer_test: FAIL");
    $finish;
  end

  function automatic bit frame_error(input logic [2:0] code, output res_t r);
    ph          = PH_HUNT;
    garbage_run = '0;
    r           = '0;
    r.kind       = KIND_ERROR;
    r.error_code = code;
    return 1'b1;
  endfunction

  // Advance the framer by one byte; return 1 when the byte yields a result.
  function automatic bit deframe_byte(input logic [7:0] b, output res_t r);
    int unsigned v;
    r = '0;
    case (ph)
      PH_HUNT: begin
        if (b == CH_HASH) begin
          ph          = PH_LEN;
          len_acc     = '0;
          seen_digit  = 1'b0;
          len_over    = 1'b0;
          garbage_run = '0;
          return 1'b0;
        end
        if (garbage_run != GARB_SAT) garbage_run++;
        if (garbage_run > garbage_limit) return frame_error(ERR_GARBAGE, r);
        return 1'b0;
      end
      PH_LEN: begin
        if (b >= CH_ZERO && b <= CH_NINE) begin
          v = 32'(len_acc) * 10 + 32'(b - CH_ZERO);
          if (v > LEN_SAT) begin
            v        = 32'(LEN_SAT);
            len_over = 1'b1;
          end
          len_acc    = v[LEN_WIDTH_DEF-1:0];
          seen_digit = 1'b1;
          return 1'b0;
        end
        if (b == CH_CR) begin
          ph = PH_CR;
          return 1'b0;
        end
        return frame_error(ERR_BAD_CHAR, r);
      end
      PH_CR: begin
        if (b != CH_LF) return frame_error(ERR_BAD_CHAR, r);
        if (!seen_digit) return frame_error(ERR_EMPTY_LEN, r);
        if (len_over || len_acc > body_limit) return frame_error(ERR_TOO_BIG, r);
        if (len_acc == '0) begin
          ph          = PH_HUNT;
          garbage_run = '0;
          r.kind      = KIND_EMPTY;
          r.last      = 1'b1;
          return 1'b1;
        end
        body_remaining = len_acc;
        ph             = PH_BODY;
        return 1'b0;
      end
      default: begin
        r.kind      = KIND_BODY;
        r.data_byte = b;
        if (body_remaining <= 1) begin
          body_remaining = '0;
          ph             = PH_HUNT;
          garbage_run    = '0;
          r.last         = 1'b1;
        end else begin
          body_remaining--;
        end
        return 1'b1;
      end
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    if (gap_quiet > 0) begin
      gap_quiet--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      gap_quiet = 50;
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit typed, input bit typed_has,
                           input res_t typed_res);
    int   gap;
    bit   got;
    res_t r;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.byte_in <= b;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    got = deframe_byte(b, r);
    if (typed) begin
      got = typed_has;
      r   = typed_res;
    end
    if (got) expected_frames.push_back(r);
  endtask

  task automatic send_stream();
    while (stream_q.size() != 0) send_byte(stream_q.pop_front(), 1'b0, 1'b0, NO_RES);
  endtask

  function automatic logic [7:0] junk_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == CH_HASH) b = b ^ 8'h01;
    return b;
  endfunction

  function automatic void push_digits(input int unsigned n);
    string s;
    s = $sformatf("%0d", n);
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) stream_q.push_back(CH_ZERO);
    for (int i = 0; i < s.len(); i++) stream_q.push_back(s[i]);
  endfunction

  // Mostly well-formed packets with random bodies; the rest broken headers,
  // raw noise and runs of junk while hunting.
  function automatic void gen_sequence();
    int          pick;
    int unsigned n;
    int unsigned cap;
    logic [7:0]  b;
    pick = $urandom_range(0, 99);
    if (pick < 68) begin
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) stream_q.push_back(junk_byte());
      stream_q.push_back(CH_HASH);
      cap = (body_limit < 24) ? 32'(body_limit) : 32'd24;
      n   = $urandom_range(0, cap);
      if (body_limit <= 40 && $urandom_range(0, 4) == 0) n = 32'(body_limit);
      push_digits(n);
      stream_q.push_back(CH_CR);
      stream_q.push_back(CH_LF);
      repeat (n) stream_q.push_back(8'($urandom_range(0, 255)));
    end else if (pick < 88) begin
      stream_q.push_back(CH_HASH);
      case ($urandom_range(0, 4))
        0: begin
          stream_q.push_back(CH_CR);
          stream_q.push_back(CH_LF);
        end
        1: begin
          if ($urandom_range(0, 1)) push_digits($urandom_range(0, 99));
          do b = 8'($urandom_range(0, 255));
          while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_CR);
          stream_q.push_back(b);
        end
        2: begin
          if ($urandom_range(0, 1)) push_digits($urandom_range(0, 99));
          stream_q.push_back(CH_CR);
          if ($urandom_range(0, 2) == 0) begin
            stream_q.push_back(CH_HASH);
          end else begin
            do b = 8'($urandom_range(0, 255));
            while (b == CH_LF);
            stream_q.push_back(b);
          end
        end
        3: begin
          if ($urandom_range(0, 1)) begin
            // at least 2000000: saturates the length
            stream_q.push_back(CH_ZERO + 8'($urandom_range(2, 9)));
            repeat ($urandom_range(6, 8)) stream_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
          end else begin
            push_digits(32'(body_limit) + 32'd1);
          end
          stream_q.push_back(CH_CR);
          stream_q.push_back(CH_LF);
        end
        default: begin
          push_digits($urandom_range(0, 99));
          stream_q.push_back(CH_LF);
        end
      endcase
    end else if (pick < 95) begin
      repeat ($urandom_range(1, 6)) stream_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      n = (garbage_limit < 64) ? garbage_limit + $urandom_range(1, 2) : $urandom_range(1, 8);
      repeat (n) stream_q.push_back(junk_byte());
    end
  endfunction

  task automatic run_random(input int budget);
    int sent;
    sent = 0;
    while (sent < budget) begin
      gen_sequence();
      sent += stream_q.size();
      send_stream();
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    if (idx == REG_MAX_BODY_LEN) body_limit = val[CFG_W-1:0];
    else if (idx == REG_GARBAGE_LIMIT) garbage_limit = val[CFG_W-1:0];
  endtask

  // Drain every pending result, let the pipeline settle, then reprogram.
  task automatic set_regs(input logic [CFG_DATA_W-1:0] body_v,
                          input logic [CFG_DATA_W-1:0] garbage_v);
    in_if.valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_reg(REG_MAX_BODY_LEN, body_v);
    write_reg(REG_GARBAGE_LIMIT, garbage_v);
    write_reg(REG_NONE, $urandom);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic void check_frame();
    res_t want;
    results_seen++;
    if (expected_frames.size() == 0) begin
      $error("unexpected result: kind %0d data_byte %02h last %0d error_code %0d",
             out_if.kind, out_if.data_byte, out_if.last, out_if.error_code);
      fail_count++;
      return;
    end
    want = expected_frames.pop_front();
    if (out_if.kind !== want.kind) begin
      $error("kind: expected %0d, got %0d", want.kind, out_if.kind);
      fail_count++;
    end
    if (out_if.data_byte !== want.data_byte) begin
      $error("data_byte: expected %02h, got %02h", want.data_byte, out_if.data_byte);
      fail_count++;
    end
    if (out_if.last !== want.last) begin
      $error("last: expected %0d, got %0d", want.last, out_if.last);
      fail_count++;
    end
    if (out_if.error_code !== want.error_code) begin
      $error("error_code: expected %0d, got %0d", want.error_code, out_if.error_code);
      fail_count++;
    end
  endfunction

  // Result side: check each transaction, then pick next cycle's ready.
  initial begin
    int r;
    stall_left   = 0;
    quiet_left   = 0;
    hold_left    = 0;
    next_hold    = 150;
    results_seen = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) check_frame();
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (results_seen >= next_hold) begin
        // long hold-off: let the block back up into its input
        hold_left = 90;
        next_hold += 400;
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if (quiet_left > 0) begin
          quiet_left--;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 2) quiet_left = 60;
          else if (r < 67) stall_left = 0;
          else if (r < 93) stall_left = $urandom_range(1, 3);
          else stall_left = $urandom_range(10, 25);
        end
      end
    end
  end

  initial begin
    fail_count     = 0;
    gap_quiet      = 0;
    body_limit     = MAX_BODY_LEN_RST;
    garbage_limit  = GARBAGE_LIMIT_RST;
    ph             = PH_HUNT;
    len_acc        = '0;
    seen_digit     = 1'b0;
    len_over       = 1'b0;
    body_remaining = '0;
    garbage_run    = '0;
    rst_ni        <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.byte_in <= '0;
    cfg_if.valid  <= 1'b0;
    cfg_if.index  <= '0;
    cfg_if.data   <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIRECTED_ROWS[i]) begin
      send_byte(DIRECTED_ROWS[i].byte_val, DIRECTED_ROWS[i].typed,
                DIRECTED_ROWS[i].has_res, DIRECTED_ROWS[i].res);
    end

    run_random(250);

    set_regs(32'd12, 32'd0);
    run_random(270);
    // upper bits set: both registers keep only the low 20 bits
    set_regs(32'hFFF0_0000, 32'hABC0_0004);
    run_random(260);
    set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_random(260);
    set_regs(32'd37, 32'd20);
    run_random(240);

    in_if.valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("length_prefixed_deframer_test: PASS");
    end else begin
      $display("length_prefixed_deframer_test: FAIL");
    end
    $finish;
  end

endmodule
